[rtl/lrubtc_pkg.sv]
// shared constants, types and helpers of the lru block tag cache
package lrubtc_pkg;

    // slot array geometry
    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // field widths
    localparam int HANDLE_W  = 32;
    localparam int OFFSET_W  = 48;
    localparam int LEN_W     = 32;
    localparam int STAMP_W   = 64;
    localparam int TOTAL_W   = 32;
    localparam int SLOT_W    = 6;
    localparam int EIU_W     = 7;

    // block size limits
    localparam int MIN_BLOCK = 'h200;
    localparam int MAX_BLOCK = 'h4000;
    localparam int BSIZE_W   = $clog2(MAX_BLOCK);

    // register port
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int CMP_W     = (CNT_W > EIU_W) ? CNT_W : EIU_W;

    // register reset values
    localparam logic [HANDLE_W-1:0] CACHE_HANDLE_RST = HANDLE_W'(1);
    localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST   = BSIZE_W'(MIN_BLOCK);
    localparam logic [EIU_W-1:0]    ENTRIES_RST      = EIU_W'(64);

    // register indexes
    typedef enum logic [1:0] {
        REG_CACHE_HANDLE   = 2'd0,
        REG_BLOCK_SIZE     = 2'd1,
        REG_ENTRIES_IN_USE = 2'd2
    } t_reg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // request seen by every cell
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [OFFSET_W-1:0] offset;
        logic                cacheable;
        logic [CNT_W-1:0]    n_active;
    } t_req;

    // search record passed from cell to cell
    typedef struct packed {
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic                free;
        logic [IDX_W-1:0]    victim;
        logic [STAMP_W-1:0]  oldest;
    } t_scan_rec;

    // slot update broadcast to the row
    typedef struct packed {
        logic                en;
        logic                tag;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] handle;
        logic [OFFSET_W-1:0] offset;
        logic [STAMP_W-1:0]  stamp;
    } t_wr_cmd;

    // number of searched slots, zero acts as one, clamped to the array size
    function automatic logic [CNT_W-1:0] active_count(input logic [EIU_W-1:0] e);
        logic [CMP_W-1:0] ev;
        logic [CNT_W-1:0] res;
        ev = CMP_W'(e);
        if (ev == '0) begin
            res = CNT_W'(1);
        end else if (ev > CMP_W'(MAX_SLOTS)) begin
            res = CNT_W'(MAX_SLOTS);
        end else begin
            res = CNT_W'(ev);
        end
        return res;
    endfunction

endpackage

[rtl/lrubtc_cell.sv]
// one slot of the tag array with its stage of the search chain
module lrubtc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [lrubtc_pkg::IDX_W-1:0] i_idx,
    input  lrubtc_pkg::t_req     i_req,
    input  lrubtc_pkg::t_scan_rec i_rec,
    input  lrubtc_pkg::t_wr_cmd  i_wr,
    output lrubtc_pkg::t_scan_rec o_rec
);
    import lrubtc_pkg::*;

    logic                r_valid;
    logic [HANDLE_W-1:0] r_handle;
    logic [OFFSET_W-1:0] r_offset;
    logic [STAMP_W-1:0]  r_stamp;
    t_scan_rec           r_rec;
    t_scan_rec           n_rec;
    logic                w_active;
    logic                w_match;
    logic                w_sel;

    assign w_active = CNT_W'(i_idx) < i_req.n_active;
    assign w_match  = r_valid && (r_handle == i_req.handle) && (r_offset == i_req.offset);
    assign w_sel    = i_wr.en && (i_wr.idx == i_idx);

    // fold this slot into the running search record
    always_comb begin
        n_rec = i_rec;
        if (w_active) begin
            if (!i_rec.hit && i_req.cacheable && w_match) begin
                n_rec.hit     = 1'b1;
                n_rec.hit_idx = i_idx;
            end
            if (!i_rec.free) begin
                if (!r_valid) begin
                    n_rec.free   = 1'b1;
                    n_rec.victim = i_idx;
                end else if (r_stamp < i_rec.oldest) begin
                    n_rec.oldest = r_stamp;
                    n_rec.victim = i_idx;
                end
            end
        end
    end

    // record stage toward the next cell
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel && i_wr.tag) begin
            r_valid <= 1'b1;
        end
    end

    // slot tag and timestamp
    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_stamp <= i_wr.stamp;
            if (i_wr.tag) begin
                r_handle <= i_wr.handle;
                r_offset <= i_wr.offset;
            end
        end
    end

    assign o_rec = r_rec;

endmodule

[rtl/lrubtc_chain.sv]
// row of slot cells; seeds the search record and returns it from the last cell
module lrubtc_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrubtc_pkg::t_req      i_req,
    input  logic [lrubtc_pkg::STAMP_W-1:0] i_use_clock,
    input  lrubtc_pkg::t_wr_cmd   i_wr,
    output lrubtc_pkg::t_scan_rec o_rec
);
    import lrubtc_pkg::*;

    t_scan_rec w_link [MAX_SLOTS+1];

    // empty record: no hit, no free slot, oldest starts at the use clock
    always_comb begin
        w_link[0]         = '0;
        w_link[0].oldest  = i_use_clock;
    end

    // one cell per slot, each feeding its right neighbor
    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        lrubtc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_req   (i_req),
            .i_rec   (w_link[g]),
            .i_wr    (i_wr),
            .o_rec   (w_link[g+1])
        );
    end

    assign o_rec = w_link[MAX_SLOTS];

endmodule

[rtl/lru_block_tag_cache_top.sv]
// lru block tag cache: register port, request control and result register
//
// Request channel i_in_valid / o_in_ready carries handle, block offset, length,
// cache enable and read complete; result channel o_out_valid / i_out_ready
// carries hit, fill, evicted, slot and the three running totals.
// A transfer happens on a rising edge with valid and ready both high.
// One request is worked at a time. After the input transfer the search record
// walks the row of slot cells, one cell per cycle; the result is registered in
// the finish state once the output register is free, and a new request is taken
// in idle. The next request may be taken while a result still waits in the
// output register; its own result then waits until the receiver takes the
// earlier one. Configuration (cache handle, block size, entries in use) is
// written over the APB port at 0x0, 0x4, 0x8; the user must write it only while
// no request is in flight, which the block does not enforce; pready is always
// high. Synchronous active-low reset marks every slot free, clears the use
// clock and counters and loads handle 1, block size 512 and 64 entries in use.
module lru_block_tag_cache_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [lrubtc_pkg::ADDR_W-1:0] paddr,
    input  logic [lrubtc_pkg::DATA_W-1:0] pwdata,
    output logic [lrubtc_pkg::DATA_W-1:0] prdata,
    output logic                 pready,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [lrubtc_pkg::HANDLE_W-1:0] i_handle,
    input  logic [lrubtc_pkg::OFFSET_W-1:0] i_block_offset,
    input  logic [lrubtc_pkg::LEN_W-1:0]    i_request_length,
    input  logic                 i_cache_enable,
    input  logic                 i_read_complete,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic                 o_fill,
    output logic                 o_evicted,
    output logic [lrubtc_pkg::SLOT_W-1:0]  o_slot,
    output logic [lrubtc_pkg::TOTAL_W-1:0] o_hit_total,
    output logic [lrubtc_pkg::TOTAL_W-1:0] o_miss_total,
    output logic [lrubtc_pkg::TOTAL_W-1:0] o_evict_total
);
    import lrubtc_pkg::*;

    // configuration registers
    logic [HANDLE_W-1:0] r_cache_handle;
    logic [BSIZE_W-1:0]  r_block_size;
    logic [EIU_W-1:0]    r_entries;

    // request registers
    logic [HANDLE_W-1:0] r_req_handle;
    logic [OFFSET_W-1:0] r_req_offset;
    logic                r_req_enable;
    logic                r_req_complete;
    logic                r_req_cacheable;

    // control and counters
    t_state              r_state;
    t_state              n_state;
    logic [IDX_W-1:0]    r_cnt;
    logic [STAMP_W-1:0]  r_use_clock;
    logic [TOTAL_W-1:0]  r_hit_cnt;
    logic [TOTAL_W-1:0]  r_miss_cnt;
    logic [TOTAL_W-1:0]  r_evict_cnt;

    // result register
    logic                r_out_valid;
    logic                r_hit;
    logic                r_fill;
    logic                r_evicted;
    logic [IDX_W-1:0]    r_slot;

    logic                w_cfg_wr;
    logic [BSIZE_W-1:0]  w_bsize;
    logic                w_in_xfer;
    logic                w_in_ready;
    logic                w_commit;
    logic                w_do_fill;
    logic [STAMP_W-1:0]  w_clock_inc;
    t_req                w_req;
    t_wr_cmd             w_wr;
    t_scan_rec           w_rec;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_bsize  = pwdata[BSIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_handle <= CACHE_HANDLE_RST;
            r_block_size   <= BLOCK_SIZE_RST;
            r_entries      <= ENTRIES_RST;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[ADDR_W-1:2]))
                REG_CACHE_HANDLE: begin
                    r_cache_handle <= pwdata[HANDLE_W-1:0];
                end
                REG_BLOCK_SIZE: begin
                    if (w_bsize >= BSIZE_W'(MIN_BLOCK)) begin
                        r_block_size <= w_bsize;
                    end
                end
                REG_ENTRIES_IN_USE: begin
                    r_entries <= pwdata[EIU_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register read
    always_comb begin
        case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_CACHE_HANDLE:   prdata = DATA_W'(r_cache_handle);
            REG_BLOCK_SIZE:     prdata = DATA_W'(r_block_size);
            REG_ENTRIES_IN_USE: prdata = DATA_W'(r_entries);
            default:            prdata = '0;
        endcase
    end

    // request capture and cacheability
    assign w_in_xfer = i_in_valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_handle    <= i_handle;
            r_req_offset    <= i_block_offset;
            r_req_enable    <= i_cache_enable;
            r_req_complete  <= i_read_complete;
            r_req_cacheable <= i_cache_enable && (i_handle != '0) &&
                               (i_handle == r_cache_handle) &&
                               (i_request_length == LEN_W'(r_block_size));
        end
    end

    // state register and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // next state, ready and commit
    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == IDX_W'(MAX_SLOTS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = w_in_ready;

    // slot row
    assign w_req.handle    = r_req_handle;
    assign w_req.offset    = r_req_offset;
    assign w_req.cacheable = r_req_cacheable;
    assign w_req.n_active  = active_count(r_entries);

    lrubtc_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_use_clock (r_use_clock),
        .i_wr        (w_wr),
        .o_rec       (w_rec)
    );

    // slot update: refresh stamp on a hit, new tag on a fill
    assign w_do_fill   = !w_rec.hit && r_req_cacheable && r_req_complete;
    assign w_clock_inc = r_use_clock + STAMP_W'(1);

    always_comb begin
        w_wr.en     = w_commit && (w_rec.hit || w_do_fill);
        w_wr.tag    = !w_rec.hit;
        w_wr.idx    = w_rec.hit ? w_rec.hit_idx : w_rec.victim;
        w_wr.handle = r_req_handle;
        w_wr.offset = r_req_offset;
        w_wr.stamp  = w_clock_inc;
    end

    // use clock and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_clock <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (w_commit) begin
            if (w_rec.hit || w_do_fill) begin
                r_use_clock <= w_clock_inc;
            end
            if (w_rec.hit) begin
                r_hit_cnt <= r_hit_cnt + TOTAL_W'(1);
            end else if (r_req_enable) begin
                r_miss_cnt <= r_miss_cnt + TOTAL_W'(1);
            end
            if (w_do_fill && !w_rec.free) begin
                r_evict_cnt <= r_evict_cnt + TOTAL_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_hit     <= w_rec.hit;
            r_fill    <= w_do_fill;
            r_evicted <= w_do_fill && !w_rec.free;
            if (w_rec.hit) begin
                r_slot <= w_rec.hit_idx;
            end else if (w_do_fill) begin
                r_slot <= w_rec.victim;
            end else begin
                r_slot <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_fill        = r_fill;
    assign o_evicted     = r_evicted;
    assign o_slot        = SLOT_W'(r_slot);
    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

`ifndef SYNTHESIS
    // a hit never allocates, and only an allocation evicts
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_fill) && (!r_evicted || r_fill))
        else $error("hit with fill or eviction without fill");

    // slot reads zero when the request neither hit nor filled
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit && !r_fill) |-> (r_slot == '0))
        else $error("nonzero slot without hit or fill");

    // a committed hit bumps the hit total by exactly one
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_rec.hit) |=> (r_hit_cnt == $past(r_hit_cnt) + TOTAL_W'(1)))
        else $error("hit total did not advance");

    // an accepted request always starts the scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("scan did not start after request transfer");
`endif

endmodule
